// File: hw/rtl/ira_pkg.sv
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types, constants and helpers of the interval room assigner.
// ----------------------------------------------------------------------------
package ira_pkg;

  localparam int MAX_ROOMS  = 256;
  localparam int TIME_BITS  = 20;
  localparam int OUT_BITS   = 9;                        // width of room fields on the port
  localparam int COUNT_BITS = $clog2(MAX_ROOMS + 1);    // holds 0..MAX_ROOMS
  localparam int ADDR_BITS  = $clog2(MAX_ROOMS);        // heap slot index
  localparam int CHILD_BITS = ADDR_BITS + 2;            // child index before range check

  // heap slot: ordered by end time, then by room number
  typedef struct packed {
    logic [TIME_BITS-1:0]  end_key;
    logic [COUNT_BITS-1:0] room;
  } heap_entry_t;

  localparam int ENTRY_BITS = $bits(heap_entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_READ,
    S_UP_CMP,
    S_DN_READ,
    S_DN_CMP,
    S_DONE
  } ira_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic up_read;
    logic up_cmp;
    logic dn_read;
    logic dn_cmp;
    logic load_out;
  } ira_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_up;
    logic go_down;
    logic up_at_root;
    logic up_move;
    logic dn_leaf;
    logic dn_move;
    logic out_free;
  } ira_stat_t;

  function automatic logic entry_before(heap_entry_t a, heap_entry_t b);
    entry_before = (a.end_key < b.end_key) ||
                   ((a.end_key == b.end_key) && (a.room < b.room));
  endfunction

endpackage

// File: hw/rtl/ira_in_if.sv
// ----------------------------------------------------------------------------
// ira_in_if
// Interval channel: one word carries one closed interval.
// ----------------------------------------------------------------------------
interface ira_in_if;
  logic                          valid;
  logic                          ready;
  logic                          restart;
  logic [ira_pkg::TIME_BITS-1:0] start_time;
  logic [ira_pkg::TIME_BITS-1:0] end_time;

  modport source (output valid, restart, start_time, end_time, input ready);
  modport sink   (input valid, restart, start_time, end_time, output ready);
endinterface

// File: hw/rtl/ira_out_if.sv
// ----------------------------------------------------------------------------
// ira_out_if
// Booking channel: one word carries the outcome for one interval.
// ----------------------------------------------------------------------------
interface ira_out_if;
  logic                         valid;
  logic                         ready;
  logic [ira_pkg::OUT_BITS-1:0] assigned_room;
  logic [ira_pkg::OUT_BITS-1:0] rooms_open;
  logic                         order_error;
  logic                         capacity_full;

  modport source (output valid, assigned_room, rooms_open, order_error, capacity_full,
                  input ready);
  modport sink   (input valid, assigned_room, rooms_open, order_error, capacity_full,
                  output ready);
endinterface

// File: hw/rtl/ira_ram.sv
// ----------------------------------------------------------------------------
// ira_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/ira_ctrl.sv
// ----------------------------------------------------------------------------
// ira_ctrl
// Sequencer: accept, sift the heap one level per read and compare step, hand over result.
// ----------------------------------------------------------------------------
module ira_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ira_pkg::ira_stat_t stat,
  output ira_pkg::ira_cmd_t  cmd
);

  ira_pkg::ira_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ira_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ira_pkg::S_IDLE: begin
        if (in_valid) begin
          if (stat.go_down) begin
            state_next = ira_pkg::S_DN_READ;
          end else if (stat.go_up) begin
            state_next = ira_pkg::S_UP_READ;
          end else begin
            state_next = ira_pkg::S_DONE;
          end
        end
      end
      ira_pkg::S_UP_READ: begin
        state_next = stat.up_at_root ? ira_pkg::S_DONE : ira_pkg::S_UP_CMP;
      end
      ira_pkg::S_UP_CMP: begin
        state_next = stat.up_move ? ira_pkg::S_UP_READ : ira_pkg::S_DONE;
      end
      ira_pkg::S_DN_READ: begin
        state_next = stat.dn_leaf ? ira_pkg::S_DONE : ira_pkg::S_DN_CMP;
      end
      ira_pkg::S_DN_CMP: begin
        state_next = stat.dn_move ? ira_pkg::S_DN_READ : ira_pkg::S_DONE;
      end
      ira_pkg::S_DONE: begin
        if (stat.out_free) begin
          state_next = ira_pkg::S_IDLE;
        end
      end
      default: state_next = ira_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ira_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ira_pkg::S_UP_READ: cmd.up_read  = 1'b1;
      ira_pkg::S_UP_CMP:  cmd.up_cmp   = 1'b1;
      ira_pkg::S_DN_READ: cmd.dn_read  = 1'b1;
      ira_pkg::S_DN_CMP:  cmd.dn_cmp   = 1'b1;
      ira_pkg::S_DONE:    cmd.load_out = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: hw/rtl/ira_datapath.sv
// ----------------------------------------------------------------------------
// ira_datapath
// Heap storage, root copy, counters, sift hole and the output register.
// ----------------------------------------------------------------------------
module ira_datapath (
  input  logic              clk,
  input  logic              rst,
  input  ira_pkg::ira_cmd_t cmd,
  output ira_pkg::ira_stat_t stat,
  ira_in_if.sink            intervals,
  ira_out_if.source         bookings
);

  // heap is mirrored in two RAMs so both children come back in one read
  logic                           wr_en;
  logic [ira_pkg::ADDR_BITS-1:0]  rd_addr_a;
  logic [ira_pkg::ADDR_BITS-1:0]  rd_addr_b;
  logic [ira_pkg::ENTRY_BITS-1:0] wr_bits;
  logic [ira_pkg::ENTRY_BITS-1:0] rd_bits_a;
  logic [ira_pkg::ENTRY_BITS-1:0] rd_bits_b;
  ira_pkg::heap_entry_t           wr_data;
  ira_pkg::heap_entry_t           rd_a;
  ira_pkg::heap_entry_t           rd_b;

  logic [ira_pkg::COUNT_BITS-1:0] count;
  logic [ira_pkg::TIME_BITS-1:0]  prev_start;
  ira_pkg::heap_entry_t           top;     // copy of slot 0
  ira_pkg::heap_entry_t           x;       // entry being sifted
  logic [ira_pkg::ADDR_BITS-1:0]  hole;
  logic [ira_pkg::COUNT_BITS-1:0] res_room;
  logic                           res_err;
  logic                           res_full;
  logic                           out_valid;

  logic [ira_pkg::COUNT_BITS-1:0] eff_count;
  logic [ira_pkg::TIME_BITS-1:0]  eff_prev;
  logic                           bad;
  logic                           reuse;
  logic                           can_open;
  logic [ira_pkg::ADDR_BITS-1:0]  parent;
  logic [ira_pkg::CHILD_BITS-1:0] left_idx;
  logic [ira_pkg::CHILD_BITS-1:0] right_idx;
  logic                           right_ok;
  logic                           pick_right;
  ira_pkg::heap_entry_t           pick;
  logic [ira_pkg::ADDR_BITS-1:0]  pick_idx;

  ira_ram #(.WIDTH(ira_pkg::ENTRY_BITS), .DEPTH(ira_pkg::MAX_ROOMS)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (hole),
    .wr_data (wr_bits),
    .rd_addr (rd_addr_a),
    .rd_data (rd_bits_a)
  );

  ira_ram #(.WIDTH(ira_pkg::ENTRY_BITS), .DEPTH(ira_pkg::MAX_ROOMS)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (hole),
    .wr_data (wr_bits),
    .rd_addr (rd_addr_b),
    .rd_data (rd_bits_b)
  );

  assign wr_bits = wr_data;
  assign rd_a    = rd_bits_a;
  assign rd_b    = rd_bits_b;

  // admission decision on the incoming word; restart applies first
  assign eff_count = intervals.restart ? '0 : count;
  assign eff_prev  = intervals.restart ? '0 : prev_start;
  assign bad       = (intervals.start_time < eff_prev) ||
                     (intervals.end_time < intervals.start_time);
  assign reuse     = (eff_count != '0) && (top.end_key < intervals.start_time);
  assign can_open  = eff_count < ira_pkg::COUNT_BITS'(ira_pkg::MAX_ROOMS);

  // heap navigation around the hole
  assign parent    = ira_pkg::ADDR_BITS'(hole - 1'b1) >> 1;
  assign left_idx  = {1'b0, hole, 1'b1};
  assign right_idx = ira_pkg::CHILD_BITS'(left_idx + 1'b1);
  assign right_ok  = right_idx < ira_pkg::CHILD_BITS'(count);
  assign pick_right = right_ok && ira_pkg::entry_before(rd_b, rd_a);
  assign pick      = pick_right ? rd_b : rd_a;
  assign pick_idx  = pick_right ? right_idx[ira_pkg::ADDR_BITS-1:0]
                                : left_idx[ira_pkg::ADDR_BITS-1:0];

  assign rd_addr_a = cmd.up_read ? parent : left_idx[ira_pkg::ADDR_BITS-1:0];
  assign rd_addr_b = right_idx[ira_pkg::ADDR_BITS-1:0];

  assign stat.go_down    = !bad && reuse;
  assign stat.go_up      = !bad && !reuse && can_open;
  assign stat.up_at_root = hole == '0;
  assign stat.up_move    = ira_pkg::entry_before(x, rd_a);
  assign stat.dn_leaf    = left_idx >= ira_pkg::CHILD_BITS'(count);
  assign stat.dn_move    = ira_pkg::entry_before(pick, x);
  assign stat.out_free   = !out_valid || bookings.ready;

  // every write lands in the hole
  always_comb begin
    wr_en   = (cmd.up_read && stat.up_at_root) || (cmd.dn_read && stat.dn_leaf) ||
              cmd.up_cmp || cmd.dn_cmp;
    wr_data = x;
    if (cmd.up_cmp && stat.up_move) begin
      wr_data = rd_a;
    end else if (cmd.dn_cmp && stat.dn_move) begin
      wr_data = pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      prev_start <= '0;
    end else if (cmd.accept) begin
      count      <= stat.go_up ? ira_pkg::COUNT_BITS'(eff_count + 1'b1) : eff_count;
      prev_start <= bad ? eff_prev : intervals.start_time;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_err   <= bad;
      res_full  <= !bad && !reuse && !can_open;
      x.end_key <= intervals.end_time;
      if (stat.go_down) begin
        res_room <= top.room;
        x.room   <= top.room;
        hole     <= '0;
      end else begin
        res_room <= stat.go_up ? ira_pkg::COUNT_BITS'(eff_count + 1'b1) : '0;
        x.room   <= ira_pkg::COUNT_BITS'(eff_count + 1'b1);
        hole     <= eff_count[ira_pkg::ADDR_BITS-1:0];
      end
    end else if ((cmd.up_cmp && stat.up_move)) begin
      hole <= parent;
    end else if (cmd.dn_cmp && stat.dn_move) begin
      hole <= pick_idx;
    end
    if (wr_en && (hole == '0)) begin
      top <= wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (bookings.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      bookings.assigned_room <= ira_pkg::OUT_BITS'(res_room);
      bookings.rooms_open    <= ira_pkg::OUT_BITS'(count);
      bookings.order_error   <= res_err;
      bookings.capacity_full <= res_full;
    end
  end

  assign bookings.valid = out_valid;

endmodule

// File: hw/rtl/interval_room_assigner.sv
// ----------------------------------------------------------------------------
// interval_room_assigner
// Greedy interval partitioning: each interval gets a room from a min-heap
// of busy rooms keyed by (end time, room number).
// ----------------------------------------------------------------------------
//
//   channel    | dir | word contents
//   -----------+-----+------------------------------------------------------
//   intervals  | in  | restart, start_time, end_time
//   bookings   | out | assigned_room, rooms_open, order_error, capacity_full
//
// Flow: one word at a time. The decision is made in the accept cycle
// against a register copy of the heap root; the sift then steps one heap
// level per RAM read state and compare state (mirrored RAM read, compare and
// write into the hole), drops the entry into its final slot in the compare
// that stops or in a read at the root or a leaf, and ends with the output
// load. A rejected word skips the sift and goes straight to the output load.
// Reset: rst clears the counts, the last start and the sequencer; the heap
// RAMs are not cleared, as only slots below the count are ever read.
// Stalls: the result waits in the output register; the next word is taken
// while it waits, and the sequencer holds in its final step only if the
// previous result is still untaken.
module interval_room_assigner (
  input  logic      clk,
  input  logic      rst,
  ira_in_if.sink    intervals,
  ira_out_if.source bookings
);

  ira_pkg::ira_cmd_t  cmd;   // sequencer commands
  ira_pkg::ira_stat_t stat;  // decision and sift status

  // sequencer: owns the handshake on the interval side
  ira_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (intervals.valid),
    .in_ready (intervals.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // heap, counters and the result register
  ira_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .intervals (intervals),
    .bookings  (bookings)
  );

endmodule

// File: dv/interval_room_assigner_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_room_assigner_test
// Self-checking bench for the interval room assigner. Intervals are queued by
// an initial block and driven one word at a time under random gaps. A local
// min-heap booking model predicts every booking word, and a monitor compares
// the words taken from the block against those predictions in order.
// ----------------------------------------------------------------------------
module interval_room_assigner_test;
  import ira_pkg::*;

  localparam int TIME_MAX      = (1 << TIME_BITS) - 1;
  localparam int TARGET_WORDS  = 1750;
  localparam int CYCLE_LIMIT   = 500_000;
  localparam int SETTLE_CYCLES = 40;    // wait after the last booking, longer than any sift
  localparam int CALM_FIRST    = 700;   // words in this window see no gaps
  localparam int CALM_LAST     = 1000;

  // one queued interval, with a flag that holds it back until the block drains
  typedef struct packed {
    logic                 restart;
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
    logic                 hold_for_drain;
  } interval_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] assigned_room;
    logic [OUT_BITS-1:0] rooms_open;
    logic                order_error;
    logic                capacity_full;
  } booking_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ira_in_if  intervals ();
  ira_out_if bookings ();

  interval_room_assigner dut (
    .clk       (clk),
    .rst       (rst),
    .intervals (intervals),
    .bookings  (bookings)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  interval_t pending[$];       // intervals not yet put on the bus
  booking_t  booking_due[$];   // predicted booking words, oldest first
  int        words_sent = 0;
  int        failures   = 0;
  int        cycles     = 0;
  bit        calm;

  // Idling is switched off for a stretch in the middle of the run.
  assign calm = (words_sent >= CALM_FIRST) && (words_sent < CALM_LAST);

  // --------------------------------------------------------------------------
  // Booking model: heap of busy rooms ordered by (end of last booking, room).
  // Only slots below slots_used are ever read.
  // --------------------------------------------------------------------------
  logic [TIME_BITS-1:0] slot_end  [MAX_ROOMS];
  int                   slot_room [MAX_ROOMS];
  int                   slots_used   = 0;
  int                   rooms_opened = 0;
  logic [TIME_BITS-1:0] last_start   = '0;

  function automatic bit slot_precedes(int a, int b);
    if (slot_end[a] != slot_end[b]) return slot_end[a] < slot_end[b];
    return slot_room[a] < slot_room[b];
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [TIME_BITS-1:0] held_end;
    int                   held_room;
    held_end     = slot_end[a];
    held_room    = slot_room[a];
    slot_end[a]  = slot_end[b];
    slot_room[a] = slot_room[b];
    slot_end[b]  = held_end;
    slot_room[b] = held_room;
  endfunction

  // Push a re-keyed root down until both children order after it.
  function automatic void sink_root();
    int at, left, right, pick;
    bit settled;
    at      = 0;
    settled = 1'b0;
    while (!settled) begin
      left  = 2 * at + 1;
      right = left + 1;
      pick  = at;
      if (left < slots_used && slot_precedes(left, pick)) pick = left;
      if (right < slots_used && slot_precedes(right, pick)) pick = right;
      if (pick == at) begin
        settled = 1'b1;
      end else begin
        swap_slots(at, pick);
        at = pick;
      end
    end
  endfunction

  // Lift a freshly added leaf while it orders before its parent.
  function automatic void float_up(int at);
    while (at > 0 && slot_precedes(at, (at - 1) / 2)) begin
      swap_slots(at, (at - 1) / 2);
      at = (at - 1) / 2;
    end
  endfunction

  function automatic booking_t book_interval(interval_t iv);
    booking_t outcome;
    outcome = '0;
    if (iv.restart) begin
      slots_used   = 0;
      rooms_opened = 0;
      last_start   = '0;
    end
    if (iv.start_time < last_start || iv.end_time < iv.start_time) begin
      // out of order: reject and leave every piece of state alone
      outcome.order_error = 1'b1;
    end else begin
      last_start = iv.start_time;
      if (slots_used > 0 && slot_end[0] < iv.start_time) begin
        // earliest finishing room is free strictly before this start: reuse it
        outcome.assigned_room = OUT_BITS'(slot_room[0]);
        slot_end[0] = iv.end_time;
        sink_root();
      end else if (rooms_opened < MAX_ROOMS) begin
        rooms_opened++;
        outcome.assigned_room = OUT_BITS'(rooms_opened);
        slot_end[slots_used]  = iv.end_time;
        slot_room[slots_used] = rooms_opened;
        slots_used++;
        float_up(slots_used - 1);
      end else begin
        // in order, but every room is taken; the start still counts
        outcome.capacity_full = 1'b1;
      end
    end
    outcome.rooms_open = OUT_BITS'(rooms_opened);
    return outcome;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic add_interval(input bit restart, input int start_t, input int end_t,
                              input bit hold);
    interval_t iv;
    iv.restart        = restart;
    iv.start_time     = start_t[TIME_BITS-1:0];
    iv.end_time       = end_t[TIME_BITS-1:0];
    iv.hold_for_drain = hold;
    pending.push_back(iv);
  endtask

  // A run of intervals with nondecreasing starts. A broken run may skip the
  // leading restart and may have order faults spliced in.
  task automatic queue_run(input bit broken);
    int     len, step, span, slip;
    longint t, e;
    len  = $urandom_range(40, 4);
    step = ($urandom_range(3) == 0) ? $urandom_range(4000, 1) : $urandom_range(12, 0);
    span = step * $urandom_range(8, 1) + $urandom_range(3, 0);
    t    = ($urandom_range(7) == 0) ? longint'(TIME_MAX - $urandom_range(2000, 0))
                                    : longint'($urandom_range(TIME_MAX, 0));
    for (int i = 0; i < len; i++) begin
      if (i > 0) t += longint'($urandom_range(step, 0));
      if (t > TIME_MAX) t = TIME_MAX;
      e = t + longint'($urandom_range(span, 0));
      if (e > TIME_MAX) e = TIME_MAX;
      if (broken && i > 0 && $urandom_range(4) == 0) begin
        slip = $urandom_range(50, 1);
        if ($urandom_range(1) && t >= slip) begin
          // start slipped back below the run's current time
          add_interval(1'b0, int'(t) - slip, int'(e), 1'b0);
        end else if (t >= slip) begin
          // end below its own start
          add_interval(1'b0, int'(t), int'(t) - slip, 1'b0);
        end else begin
          add_interval(1'b0, int'(t), 0, 1'b0);
        end
      end else begin
        add_interval((i == 0) ? (!broken || $urandom_range(1)) : 1'b0,
                     int'(t), int'(e), $urandom_range(99) == 0);
      end
    end
  endtask

  // Open every room with bookings that never end, then ask for more.
  task automatic queue_fill_forever();
    for (int i = 0; i < MAX_ROOMS + 2; i++) add_interval(i == 0, i, TIME_MAX, 1'b0);
    add_interval(1'b0, 300, TIME_MAX, 1'b0);
    add_interval(1'b0, 0, 5, 1'b0);          // order fault while full
  endtask

  // Open every room with staggered ends, hit the ceiling, then free the first.
  task automatic queue_fill_then_free();
    for (int i = 0; i < MAX_ROOMS; i++) add_interval(i == 0, 10, 10 + i, i == 0);
    add_interval(1'b0, 10, 10, 1'b0);        // no room ends before 10
    add_interval(1'b0, 11, 40, 1'b0);        // room 1 ended at 10: reuse
    add_interval(1'b0, 11, 11, 1'b0);        // room 2 ends at 11: still full
  endtask

  // --------------------------------------------------------------------------
  // Interval driver: advance to the next queued word once the current one is
  // taken, predicting its booking at the edge that accepts it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_intervals
    interval_t on_bus, nxt;
    bit        taken;
    if (rst) begin
      intervals.valid <= 1'b0;
    end else begin
      taken = intervals.valid && intervals.ready;
      if (taken) begin
        on_bus = {intervals.restart, intervals.start_time, intervals.end_time, 1'b0};
        booking_due.push_back(book_interval(on_bus));
        words_sent++;
      end
      if (!intervals.valid || taken) begin
        if (pending.size() != 0 &&
            !(pending[0].hold_for_drain && booking_due.size() != 0) &&
            (calm || $urandom_range(99) >= 10)) begin
          nxt = pending.pop_front();
          intervals.valid      <= 1'b1;
          intervals.restart    <= nxt.restart;
          intervals.start_time <= nxt.start_time;
          intervals.end_time   <= nxt.end_time;
        end else begin
          intervals.valid <= 1'b0;
        end
      end
    end
  end

  // Stall the booking channel now and then, except in the calm window.
  always @(posedge clk) begin
    if (rst) begin
      bookings.ready <= 1'b0;
    end else begin
      bookings.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  task automatic check_field(input string field, input logic [OUT_BITS-1:0] want,
                             input logic [OUT_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endtask

  // Booking monitor: compare each taken word with the oldest prediction.
  always @(posedge clk) begin : watch_bookings
    booking_t want;
    if (!rst && bookings.valid && bookings.ready) begin
      if (booking_due.size() == 0) begin
        $error("booking word with no interval outstanding");
        failures++;
      end else begin
        want = booking_due.pop_front();
        check_field("assigned_room", want.assigned_room, bookings.assigned_room);
        check_field("rooms_open", want.rooms_open, bookings.rooms_open);
        check_field("order_error", OUT_BITS'(want.order_error),
                    OUT_BITS'(bookings.order_error));
        check_field("capacity_full", OUT_BITS'(want.capacity_full),
                    OUT_BITS'(bookings.capacity_full));
      end
    end
  end

  // Watchdog: drop the run if it stops making progress.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    intervals.valid      = 1'b0;
    intervals.restart    = 1'b0;
    intervals.start_time = '0;
    intervals.end_time   = '0;
    bookings.ready       = 1'b0;

    // Directed: ties, touching ends, order faults, time extremes, restarts.
    add_interval(1'b1, 0, 0, 1'b0);                 // first room
    add_interval(1'b0, 0, 0, 1'b0);                 // touching at zero: new room
    add_interval(1'b0, 1, 5, 1'b0);                 // equal ends: lower room first
    add_interval(1'b0, 1, 5, 1'b0);
    add_interval(1'b0, 5, 9, 1'b0);                 // end equal to start: not free
    add_interval(1'b0, 6, 6, 1'b0);
    add_interval(1'b0, 4, 10, 1'b0);                // start below previous
    add_interval(1'b0, 7, 6, 1'b0);                 // end below start
    add_interval(1'b0, 7, 7, 1'b0);
    add_interval(1'b1, TIME_MAX, TIME_MAX, 1'b0);
    add_interval(1'b0, TIME_MAX, TIME_MAX, 1'b0);
    add_interval(1'b0, 0, TIME_MAX, 1'b0);          // back to zero without restart
    add_interval(1'b1, 0, TIME_MAX, 1'b0);
    add_interval(1'b1, 5, 3, 1'b0);                 // restart on a faulty word
    add_interval(1'b0, 0, 0, 1'b0);
    add_interval(1'b0, 'h55555, 'hAAAAA, 1'b0);
    add_interval(1'b0, 'hAAAAA, TIME_MAX, 1'b0);
    add_interval(1'b0, 'hFFFFE, 'hFFFFE, 1'b1);     // wait for the block to drain

    queue_fill_forever();
    while (pending.size() < 900) begin
      case ($urandom_range(9))
        0:       add_interval($urandom_range(1) == 1, $urandom_range(TIME_MAX, 0),
                              $urandom_range(TIME_MAX, 0), 1'b0);
        1:       queue_run(1'b1);
        default: queue_run(1'b0);
      endcase
    end
    queue_fill_then_free();
    while (pending.size() < TARGET_WORDS) begin
      case ($urandom_range(9))
        0:       add_interval($urandom_range(1) == 1, $urandom_range(TIME_MAX, 0),
                              $urandom_range(TIME_MAX, 0), 1'b0);
        1:       queue_run(1'b1);
        default: queue_run(1'b0);
      endcase
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Hold until every word is on its way, every booking is back, then settle.
    while (pending.size() != 0 || intervals.valid) @(posedge clk);
    while (booking_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ira_pkg.sv
hw/rtl/ira_in_if.sv
hw/rtl/ira_out_if.sv
hw/rtl/ira_ram.sv
hw/rtl/ira_ctrl.sv
hw/rtl/ira_datapath.sv
hw/rtl/interval_room_assigner.sv
dv/interval_room_assigner_test.sv
